// File: rtl/core/cls_pkg.sv
// Shared types, constants and helper functions of the contour smoother.
package cls_pkg;

    localparam int MAX_VERTICES  = 65536;
    localparam int FRACTION_BITS = 16;
    localparam int CNT_W         = $clog2(MAX_VERTICES) + 1;
    localparam int IDX_W         = 16;
    localparam int MT_W          = 31;
    localparam int QUEUE_DEPTH   = 4;
    localparam int REG_TRAVEL_CAP = 0;

    typedef struct packed {
        logic signed [31:0] x_in;
        logic signed [31:0] y_in;
        logic               closes_contour;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] x_out;
        logic signed [31:0] y_out;
        logic [IDX_W-1:0]   vertex_index;
        logic               final_of_contour;
    } out_item_t;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
    } vertex_t;

    // one vertex to smooth: previous, self, next
    typedef struct packed {
        vertex_t          p;
        vertex_t          s;
        vertex_t          n;
        logic [IDX_W-1:0] idx;
        logic             fin;
        logic             pass;
    } job_t;

    // round half away from zero at fb fraction bits, saturate to 32 bits
    function automatic logic signed [31:0] round_sat(input logic signed [63:0] q,
                                                      input int unsigned fb);
        logic        neg;
        logic [63:0] mag;
        logic [63:0] r;
        neg = q[63];
        mag = neg ? 64'(-q) : 64'(q);
        r   = (mag + (64'(1) << (fb - 1))) >> fb;
        if (!neg) begin
            round_sat = (r > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : signed'(r[31:0]);
        end else begin
            round_sat = (r > 64'h8000_0000) ? 32'sh8000_0000 : signed'(32'(-r[31:0]));
        end
    endfunction

    function automatic logic [IDX_W-1:0] rep_index(input logic [CNT_W-1:0] k);
        logic [CNT_W-1:0] lim;
        lim = CNT_W'(MAX_VERTICES - 1);
        rep_index = (k > lim) ? IDX_W'(lim) : IDX_W'(k);
    endfunction

endpackage

// File: rtl/core/cls_front.sv
// Front end: vertex window, contour bookkeeping and job issue.
module cls_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  cls_pkg::in_item_t s_data,
    output logic              q_valid,
    input  logic              q_ready,
    output cls_pkg::job_t     q_job
);

    cls_pkg::vertex_t first_reg, second_reg, third_reg, older_reg, newer_reg;
    cls_pkg::vertex_t first_next, second_next, third_next, older_next, newer_next;
    logic [cls_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    cls_pkg::job_t [3:0] buf_reg, jobs;
    logic [2:0] pend_reg, pend_next, new_n;
    logic [1:0] ptr_reg, ptr_next;
    cls_pkg::vertex_t cur;
    logic accept, close;

    function automatic cls_pkg::job_t mk_job(input cls_pkg::vertex_t p, input cls_pkg::vertex_t s,
                                             input cls_pkg::vertex_t n,
                                             input logic [cls_pkg::IDX_W-1:0] idx,
                                             input logic fin, input logic pass);
        cls_pkg::job_t j;
        j.p = p; j.s = s; j.n = n; j.idx = idx; j.fin = fin; j.pass = pass;
        mk_job = j;
    endfunction

    assign s_ready = (pend_reg == 3'd0);
    assign accept  = s_valid && s_ready;
    assign close   = s_data.closes_contour;
    assign cur.x   = s_data.x_in;
    assign cur.y   = s_data.y_in;
    assign q_valid = (pend_reg != 3'd0);
    assign q_job   = buf_reg[ptr_reg];

    always_comb begin
        first_next  = first_reg;
        second_next = second_reg;
        third_next  = third_reg;
        older_next  = older_reg;
        newer_next  = newer_reg;
        cnt_next    = cnt_reg;
        jobs        = '0;
        new_n       = 3'd0;
        case (cnt_reg)
            cls_pkg::CNT_W'(0): begin
                first_next = cur;
                if (close) begin
                    jobs[0] = mk_job(cur, cur, cur, '0, 1'b1, 1'b1);
                    new_n = 3'd1;
                end else begin
                    cnt_next = cls_pkg::CNT_W'(1);
                end
            end
            cls_pkg::CNT_W'(1): begin
                second_next = cur;
                if (close) begin
                    jobs[0] = mk_job(cur, cur, cur, 16'd1, 1'b0, 1'b1);
                    jobs[1] = mk_job(first_reg, first_reg, first_reg, '0, 1'b1, 1'b1);
                    new_n = 3'd2;
                    cnt_next = '0;
                end else begin
                    cnt_next = cls_pkg::CNT_W'(2);
                end
            end
            cls_pkg::CNT_W'(2): begin
                third_next = cur;
                if (close) begin
                    jobs[0] = mk_job(second_reg, second_reg, second_reg, 16'd1, 1'b0, 1'b1);
                    jobs[1] = mk_job(cur, cur, cur, 16'd2, 1'b0, 1'b1);
                    jobs[2] = mk_job(first_reg, first_reg, first_reg, '0, 1'b1, 1'b1);
                    new_n = 3'd3;
                    cnt_next = '0;
                end else begin
                    cnt_next = cls_pkg::CNT_W'(3);
                end
            end
            cls_pkg::CNT_W'(3): begin
                jobs[0] = mk_job(first_reg, second_reg, third_reg, 16'd1, 1'b0, 1'b0);
                jobs[1] = mk_job(second_reg, third_reg, cur, 16'd2, 1'b0, 1'b0);
                older_next = third_reg;
                newer_next = cur;
                if (close) begin
                    jobs[2] = mk_job(third_reg, cur, first_reg, 16'd3, 1'b0, 1'b0);
                    jobs[3] = mk_job(cur, first_reg, second_reg, '0, 1'b1, 1'b0);
                    new_n = 3'd4;
                    cnt_next = '0;
                end else begin
                    new_n = 3'd2;
                    cnt_next = cls_pkg::CNT_W'(4);
                end
            end
            default: begin
                jobs[0] = mk_job(older_reg, newer_reg, cur,
                                 cls_pkg::rep_index(cnt_reg - cls_pkg::CNT_W'(1)), 1'b0, 1'b0);
                older_next = newer_reg;
                newer_next = cur;
                if (close) begin
                    jobs[1] = mk_job(newer_reg, cur, first_reg,
                                     cls_pkg::rep_index(cnt_reg), 1'b0, 1'b0);
                    jobs[2] = mk_job(cur, first_reg, second_reg, '0, 1'b1, 1'b0);
                    new_n = 3'd3;
                    cnt_next = '0;
                end else begin
                    new_n = 3'd1;
                    if (cnt_reg < cls_pkg::CNT_W'(cls_pkg::MAX_VERTICES)) begin
                        cnt_next = cnt_reg + cls_pkg::CNT_W'(1);
                    end
                end
            end
        endcase
    end

    always_comb begin
        pend_next = pend_reg;
        ptr_next  = ptr_reg;
        if (accept) begin
            pend_next = new_n;
            ptr_next  = 2'd0;
        end else if (q_valid && q_ready) begin
            pend_next = pend_reg - 3'd1;
            ptr_next  = ptr_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            first_reg  <= '0;
            second_reg <= '0;
            third_reg  <= '0;
            older_reg  <= '0;
            newer_reg  <= '0;
            cnt_reg    <= '0;
            pend_reg   <= 3'd0;
            ptr_reg    <= 2'd0;
        end else begin
            if (accept) begin
                first_reg  <= first_next;
                second_reg <= second_next;
                third_reg  <= third_next;
                older_reg  <= older_next;
                newer_reg  <= newer_next;
                cnt_reg    <= cnt_next;
            end
            pend_reg <= pend_next;
            ptr_reg  <= ptr_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            buf_reg <= jobs;
        end
    end

endmodule

// File: rtl/core/cls_queue.sv
// Small job FIFO between front and back end.
module cls_queue (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          wr_valid,
    output logic          wr_ready,
    input  cls_pkg::job_t wr_job,
    output logic          rd_valid,
    input  logic          rd_ready,
    output cls_pkg::job_t rd_job
);

    localparam int PW = $clog2(cls_pkg::QUEUE_DEPTH);

    cls_pkg::job_t mem [cls_pkg::QUEUE_DEPTH];
    logic [PW-1:0] wp_reg, rp_reg;
    logic [PW:0]   fill_reg;
    logic push, pop;

    assign wr_ready = (fill_reg != (PW+1)'(cls_pkg::QUEUE_DEPTH));
    assign rd_valid = (fill_reg != '0);
    assign rd_job   = mem[rp_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg   <= '0;
            rp_reg   <= '0;
            fill_reg <= '0;
        end else begin
            if (push) wp_reg <= wp_reg + PW'(1);
            if (pop)  rp_reg <= rp_reg + PW'(1);
            if (push && !pop)      fill_reg <= fill_reg + (PW+1)'(1);
            else if (pop && !push) fill_reg <= fill_reg - (PW+1)'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wp_reg] <= wr_job;
        end
    end

endmodule

// File: rtl/core/cls_back.sv
// Back end: clamped smoothing of one vertex with shared multiplier, sqrt and divide.
module cls_back (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     job_valid,
    output logic                     job_ready,
    input  cls_pkg::job_t            job,
    input  logic [cls_pkg::MT_W-1:0] travel_cap,
    output logic                     m_valid,
    input  logic                     m_ready,
    output cls_pkg::out_item_t       m_data
);

    localparam int FB   = cls_pkg::FRACTION_BITS;
    localparam int QW   = FB + 1;
    localparam int MXW  = QW + cls_pkg::MT_W;

    typedef enum logic [13:0] {
        ST_IDLE = 14'b00000000000001,
        ST_SQA  = 14'b00000000000010,
        ST_SQB  = 14'b00000000000100,
        ST_SQT  = 14'b00000000001000,
        ST_CMP  = 14'b00000000010000,
        ST_NORM = 14'b00000000100000,
        ST_SQ2A = 14'b00000001000000,
        ST_SQ2B = 14'b00000010000000,
        ST_ROOT = 14'b00000100000000,
        ST_DIV  = 14'b00001000000000,
        ST_MX   = 14'b00010000000000,
        ST_MY   = 14'b00100000000000,
        ST_RND  = 14'b01000000000000,
        ST_FIN  = 14'b10000000000000
    } st_t;

    st_t st_reg;
    cls_pkg::vertex_t s_reg;
    logic [cls_pkg::IDX_W-1:0] idx_reg;
    logic fin_reg;
    logic signed [33:0] dx_reg, dy_reg;
    logic [33:0] a_reg, b_reg;
    logic [67:0] acc_reg, lim_reg;
    logic [61:0] num_reg;
    logic [33:0] rem_reg;
    logic [30:0] root_reg;
    logic [31:0] remx_reg, remy_reg;
    logic [QW-1:0] lowx_reg, lowy_reg, qx_reg, qy_reg;
    logic [4:0] cnt_reg;
    logic [MXW-1:0] mx_reg, my_reg;
    logic signed [31:0] rx_reg, ry_reg;
    cls_pkg::out_item_t out_reg;
    logic out_valid_reg;

    logic [33:0] ma, mb, mmax;
    logic [67:0] prod;
    logic [32:0] t4;
    logic signed [33:0] jdx, jdy;
    logic [33:0] rem2, trial;
    logic [31:0] rx2, ry2;
    logic load_out;

    assign t4   = {travel_cap, 2'b00};
    assign prod = ma * mb;
    assign mmax = (a_reg > b_reg) ? a_reg : b_reg;
    assign jdx  = 34'(job.p.x) + 34'(job.n.x) - (34'(job.s.x) <<< 1);
    assign jdy  = 34'(job.p.y) + 34'(job.n.y) - (34'(job.s.y) <<< 1);
    assign rem2  = {rem_reg[31:0], num_reg[61:60]};
    assign trial = {1'b0, root_reg, 2'b01};
    assign rx2   = {remx_reg[30:0], lowx_reg[QW-1]};
    assign ry2   = {remy_reg[30:0], lowy_reg[QW-1]};

    assign job_ready = (st_reg == ST_IDLE);
    assign load_out  = (st_reg == ST_FIN) && (!out_valid_reg || m_ready);
    assign m_valid   = out_valid_reg;
    assign m_data    = out_reg;

    always_comb begin
        ma = '0;
        mb = '0;
        unique case (st_reg)
            ST_SQA, ST_SQ2A: begin ma = a_reg; mb = a_reg; end
            ST_SQB, ST_SQ2B: begin ma = b_reg; mb = b_reg; end
            ST_SQT:          begin ma = 34'(t4); mb = 34'(t4); end
            ST_MX:           begin ma = 34'(qx_reg); mb = 34'(travel_cap); end
            ST_MY:           begin ma = 34'(qy_reg); mb = 34'(travel_cap); end
            default:         begin ma = '0; mb = '0; end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg        <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            if (load_out) out_valid_reg <= 1'b1;
            else if (m_ready) out_valid_reg <= 1'b0;
            unique case (st_reg)
                ST_IDLE: if (job_valid) begin
                    if (job.pass || travel_cap == '0) st_reg <= ST_FIN;
                    else st_reg <= ST_SQA;
                end
                ST_SQA:  st_reg <= ST_SQB;
                ST_SQB:  st_reg <= ST_SQT;
                ST_SQT:  st_reg <= ST_CMP;
                ST_CMP:  st_reg <= (acc_reg > lim_reg) ? ST_NORM : ST_FIN;
                ST_NORM: if (mmax[33:30] == '0 && mmax[29]) st_reg <= ST_SQ2A;
                ST_SQ2A: st_reg <= ST_SQ2B;
                ST_SQ2B: st_reg <= ST_ROOT;
                ST_ROOT: if (cnt_reg == '0) st_reg <= ST_DIV;
                ST_DIV:  if (cnt_reg == '0) st_reg <= ST_MX;
                ST_MX:   st_reg <= ST_MY;
                ST_MY:   st_reg <= ST_RND;
                ST_RND:  st_reg <= ST_FIN;
                ST_FIN:  if (load_out) st_reg <= ST_IDLE;
                default: st_reg <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        unique case (st_reg)
            ST_IDLE: if (job_valid) begin
                s_reg   <= job.s;
                idx_reg <= job.idx;
                fin_reg <= job.fin;
                dx_reg  <= jdx;
                dy_reg  <= jdy;
                a_reg   <= jdx[33] ? 34'(-jdx) : 34'(jdx);
                b_reg   <= jdy[33] ? 34'(-jdy) : 34'(jdy);
                rx_reg  <= job.s.x;
                ry_reg  <= job.s.y;
            end
            ST_SQA, ST_SQ2A: acc_reg <= prod;
            ST_SQB: acc_reg <= acc_reg + prod;
            ST_SQT: lim_reg <= prod;
            ST_CMP: begin
                rx_reg <= cls_pkg::round_sat((64'(s_reg.x) <<< 2) + 64'(dx_reg), 2);
                ry_reg <= cls_pkg::round_sat((64'(s_reg.y) <<< 2) + 64'(dy_reg), 2);
            end
            ST_NORM: begin
                if (mmax[33:30] != '0) begin
                    a_reg <= a_reg >> 1;
                    b_reg <= b_reg >> 1;
                end else if (!mmax[29]) begin
                    a_reg <= a_reg << 1;
                    b_reg <= b_reg << 1;
                end
            end
            ST_SQ2B: begin
                num_reg  <= 62'(acc_reg + prod);
                rem_reg  <= '0;
                root_reg <= '0;
                cnt_reg  <= 5'd30;
            end
            ST_ROOT: begin
                if (rem2 >= trial) begin
                    rem_reg  <= rem2 - trial;
                    root_reg <= {root_reg[29:0], 1'b1};
                end else begin
                    rem_reg  <= rem2;
                    root_reg <= {root_reg[29:0], 1'b0};
                end
                num_reg <= num_reg << 2;
                if (cnt_reg == '0) begin
                    remx_reg <= 32'(a_reg >> 1);
                    remy_reg <= 32'(b_reg >> 1);
                    lowx_reg <= {a_reg[0], {FB{1'b0}}};
                    lowy_reg <= {b_reg[0], {FB{1'b0}}};
                    cnt_reg  <= 5'(QW - 1);
                end else begin
                    cnt_reg <= cnt_reg - 5'd1;
                end
            end
            ST_DIV: begin
                if (rx2 >= {1'b0, root_reg}) begin
                    remx_reg <= rx2 - {1'b0, root_reg};
                    qx_reg   <= {qx_reg[QW-2:0], 1'b1};
                end else begin
                    remx_reg <= rx2;
                    qx_reg   <= {qx_reg[QW-2:0], 1'b0};
                end
                if (ry2 >= {1'b0, root_reg}) begin
                    remy_reg <= ry2 - {1'b0, root_reg};
                    qy_reg   <= {qy_reg[QW-2:0], 1'b1};
                end else begin
                    remy_reg <= ry2;
                    qy_reg   <= {qy_reg[QW-2:0], 1'b0};
                end
                lowx_reg <= lowx_reg << 1;
                lowy_reg <= lowy_reg << 1;
                cnt_reg  <= cnt_reg - 5'd1;
            end
            ST_MX: mx_reg <= MXW'(prod);
            ST_MY: begin
                my_reg <= MXW'(prod);
                rx_reg <= cls_pkg::round_sat(dx_reg[33] ?
                              (64'(s_reg.x) <<< FB) - 64'(mx_reg) :
                              (64'(s_reg.x) <<< FB) + 64'(mx_reg), FB);
            end
            ST_RND: begin
                ry_reg <= cls_pkg::round_sat(dy_reg[33] ?
                              (64'(s_reg.y) <<< FB) - 64'(my_reg) :
                              (64'(s_reg.y) <<< FB) + 64'(my_reg), FB);
            end
            default: begin
            end
        endcase
        if (load_out) begin
            out_reg.x_out            <= rx_reg;
            out_reg.y_out            <= ry_reg;
            out_reg.vertex_index     <= idx_reg;
            out_reg.final_of_contour <= fin_reg;
        end
    end

endmodule

// File: rtl/core/contour_laplacian_smoother.sv
// Top level of the contour Laplacian smoother: front end, job queue, back end, APB registers.
//
//  channel   ports                         payload
//  input     s_valid / s_ready / s_data    in_item_t : x_in, y_in, closes_contour
//  result    m_valid / m_ready / m_data    out_item_t: x_out, y_out, vertex_index, final
//  config    psel penable pwrite paddr ... travel cap at byte 0
//
// In the back end a pass-through vertex goes straight to the output stage, an
// unclamped move ends after the compare, and a clamped one also runs the normalize
// shifter (one bit a cycle), the 31-step square root and the 17-step divider.
// The front end takes one item a cycle while its job buffer is empty and then
// issues one job per cycle into a 4-deep queue while it has room. Reset is synchronous,
// active low, clears control state and the front-end window only; no clearing pass.
// Output register lets the back end start the next job while a result waits for m_ready.
module contour_laplacian_smoother (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  cls_pkg::in_item_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output cls_pkg::out_item_t m_data,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    logic [cls_pkg::MT_W-1:0] travel_cap_reg;
    logic          f_valid, f_ready, b_valid, b_ready;
    cls_pkg::job_t f_job, b_job;
    logic          sel_mt;

    // single register: index taken from the word address
    assign sel_mt = (32'(paddr[2]) == cls_pkg::REG_TRAVEL_CAP);
    assign pready = 1'b1;
    assign prdata = sel_mt ? {1'b0, travel_cap_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            travel_cap_reg <= '0;
        end else if (psel && penable && pwrite && sel_mt) begin
            travel_cap_reg <= pwdata[cls_pkg::MT_W-1:0];
        end
    end

    // window + classification, emits up to four jobs per closing item
    cls_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_valid (f_valid),
        .q_ready (f_ready),
        .q_job   (f_job)
    );

    cls_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (f_valid),
        .wr_ready (f_ready),
        .wr_job   (f_job),
        .rd_valid (b_valid),
        .rd_ready (b_ready),
        .rd_job   (b_job)
    );

    // iterative arithmetic, one vertex at a time
    cls_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .job_valid  (b_valid),
        .job_ready  (b_ready),
        .job        (b_job),
        .travel_cap (travel_cap_reg),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

    // a closing item always leaves jobs to issue, so input stalls next cycle
    a_close_stalls: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_data.closes_contour |=> !s_ready)
        else $error("input not stalled after closing item");

    // last result of a contour is always vertex 0
    a_final_is_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.final_of_contour |-> m_data.vertex_index == '0)
        else $error("final result with nonzero index");

    // jobs issued by the front end never come out of an empty queue
    a_queue_fed: assert property (@(posedge aclk) disable iff (!aresetn)
        !f_valid && !b_valid |=> !b_valid)
        else $error("queue produced a job from nothing");

endmodule

// File: dv/tb_contour_laplacian_smoother.sv
// Self-checking testbench for the contour Laplacian smoother.
module tb_contour_laplacian_smoother;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int     CYCLE_LIMIT = 4_000_000;
    localparam int     SETTLE      = 400;      // extra wait after the last expected result
    localparam int     ADDR_STEP   = 4;
    localparam longint COORD_MAX   = 64'sd2147483647;
    localparam longint COORD_MIN   = -64'sd2147483648;

    // Shape of a bare vertex inside the predictor; 64 bits leave room for sums.
    typedef struct {
        longint x;
        longint y;
    } point_t;

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    cls_pkg::in_item_t  s_data;
    logic               m_valid;
    logic               m_ready;
    cls_pkg::out_item_t m_data;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [2:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;

    contour_laplacian_smoother uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // ------------------------------------------------------------------
    // Predictor state: a private copy of the window and of the travel cap.
    // ------------------------------------------------------------------
    logic [cls_pkg::MT_W-1:0] travel_limit;
    point_t                   head0, head1, head2, trail_old, trail_new;
    int                       seen_in_contour;
    cls_pkg::out_item_t       pending_vertices[$];

    int   mismatches;
    int   items_sent;
    int   results_seen;
    int   contours_sent;
    int   clamp_hits;
    int   cycles;
    int   rx_hold;          // receiver hold-off, counted down by its own process
    int   hold_ask;         // hold-off length requested by a test
    bit   steady_flow;      // no random gaps on either side

    initial begin
        aclk = 1'b0;
    end
    always #10 aclk = ~aclk;

    // Watchdog over the whole run.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d vertices still pending",
                     cycles, pending_vertices.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Gap length: mostly none or short, now and then long.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (steady_flow || roll < 45) begin
            pick_gap = 0;
        end else if (roll < 92) begin
            pick_gap = $urandom_range(1, 3);
        end else begin
            pick_gap = $urandom_range(10, 40);
        end
    endfunction

    // ------------------------------------------------------------------
    // Arithmetic of the smoother
    // ------------------------------------------------------------------
    function automatic longint unsigned magnitude(input longint v);
        magnitude = (v < 0) ? longint'(-v) : v;
    endfunction

    // round half away from zero at fb fraction bits, clip to 32 bits signed
    function automatic longint round_clip(input longint q, input int fb);
        longint unsigned r;
        r = (magnitude(q) + (64'd1 << (fb - 1))) >> fb;
        if (q >= 0) begin
            round_clip = (r > 64'h7FFF_FFFF) ? 64'sh7FFF_FFFF : longint'(r);
        end else begin
            round_clip = (r > 64'h8000_0000) ? -64'sh8000_0000 : -longint'(r);
        end
    endfunction

    function automatic longint unsigned floor_sqrt(input longint unsigned v);
        longint unsigned root, probe;
        root  = 0;
        probe = 64'd1 << 62;
        while (probe > v) probe = probe >> 2;
        while (probe != 0) begin
            if (v >= root + probe) begin
                v    = v - (root + probe);
                root = (root >> 1) + probe;
            end else begin
                root = root >> 1;
            end
            probe = probe >> 2;
        end
        floor_sqrt = root;
    endfunction

    // New position of s between neighbors p and n.
    function automatic point_t relax_vertex(input point_t p, input point_t s, input point_t n);
        point_t          o;
        longint          dx, dy;
        longint unsigned a, b, big, root, ux, uy, mx, my;
        logic [127:0]    len_sq, reach_sq;
        if (travel_limit == 0) begin
            return s;
        end
        dx = p.x + n.x - 2 * s.x;
        dy = p.y + n.y - 2 * s.y;
        a  = magnitude(dx);
        b  = magnitude(dy);
        len_sq   = 128'(a) * 128'(a) + 128'(b) * 128'(b);
        reach_sq = 128'(4 * longint'(travel_limit)) * 128'(4 * longint'(travel_limit));
        if (len_sq <= reach_sq) begin
            o.x = round_clip(4 * s.x + dx, 2);
            o.y = round_clip(4 * s.y + dy, 2);
            return o;
        end
        clamp_hits++;
        // bring the larger magnitude into [2^29, 2^30) before the root
        big = (a > b) ? a : b;
        while (big >= (64'd1 << 30)) begin
            a = a >> 1; b = b >> 1; big = big >> 1;
        end
        while (big < (64'd1 << 29)) begin
            a = a << 1; b = b << 1; big = big << 1;
        end
        root = floor_sqrt(a * a + b * b);
        ux   = (a << cls_pkg::FRACTION_BITS) / root;
        uy   = (b << cls_pkg::FRACTION_BITS) / root;
        mx   = ux * longint'(travel_limit);
        my   = uy * longint'(travel_limit);
        o.x  = round_clip((s.x <<< cls_pkg::FRACTION_BITS) +
                          ((dx < 0) ? -longint'(mx) : longint'(mx)),
                          cls_pkg::FRACTION_BITS);
        o.y  = round_clip((s.y <<< cls_pkg::FRACTION_BITS) +
                          ((dy < 0) ? -longint'(my) : longint'(my)),
                          cls_pkg::FRACTION_BITS);
        return o;
    endfunction

    function automatic void queue_vertex(input point_t v, input int idx, input bit fin);
        cls_pkg::out_item_t r;
        r.x_out            = v.x[31:0];
        r.y_out            = v.y[31:0];
        r.vertex_index     = (idx > cls_pkg::MAX_VERTICES - 1) ?
                             cls_pkg::IDX_W'(cls_pkg::MAX_VERTICES - 1) :
                             cls_pkg::IDX_W'(idx);
        r.final_of_contour = fin;
        pending_vertices.push_back(r);
    endfunction

    // Expected results for one accepted vertex.
    function automatic void predict_vertex(input cls_pkg::in_item_t it);
        point_t cur;
        bit     closing;
        int     c;
        cur.x   = longint'(it.x_in);
        cur.y   = longint'(it.y_in);
        closing = it.closes_contour;
        c       = seen_in_contour;
        if (closing) contours_sent++;
        case (c)
            0: begin
                head0 = cur;
                if (closing) queue_vertex(head0, 0, 1'b1);
                else seen_in_contour = 1;
            end
            1: begin
                head1 = cur;
                if (closing) begin
                    queue_vertex(head1, 1, 1'b0);
                    queue_vertex(head0, 0, 1'b1);
                    seen_in_contour = 0;
                end else begin
                    seen_in_contour = 2;
                end
            end
            2: begin
                head2 = cur;
                if (closing) begin
                    queue_vertex(head1, 1, 1'b0);
                    queue_vertex(head2, 2, 1'b0);
                    queue_vertex(head0, 0, 1'b1);
                    seen_in_contour = 0;
                end else begin
                    seen_in_contour = 3;
                end
            end
            3: begin
                queue_vertex(relax_vertex(head0, head1, head2), 1, 1'b0);
                queue_vertex(relax_vertex(head1, head2, cur), 2, 1'b0);
                trail_old = head2;
                trail_new = cur;
                if (closing) begin
                    queue_vertex(relax_vertex(head2, cur, head0), 3, 1'b0);
                    queue_vertex(relax_vertex(cur, head0, head1), 0, 1'b1);
                    seen_in_contour = 0;
                end else begin
                    seen_in_contour = 4;
                end
            end
            default: begin
                queue_vertex(relax_vertex(trail_old, trail_new, cur), c - 1, 1'b0);
                trail_old = trail_new;
                trail_new = cur;
                if (closing) begin
                    queue_vertex(relax_vertex(trail_old, trail_new, head0), c, 1'b0);
                    queue_vertex(relax_vertex(trail_new, head0, head1), 0, 1'b1);
                    seen_in_contour = 0;
                end else if (c < cls_pkg::MAX_VERTICES) begin
                    seen_in_contour = c + 1;
                end
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Result side: ready pattern and checker
    // ------------------------------------------------------------------
    always @(negedge aclk) begin
        if (hold_ask > 0) begin
            m_ready  <= 1'b0;
            rx_hold  <= hold_ask;
            hold_ask = 0;
        end else if (rx_hold > 0) begin
            m_ready <= 1'b0;
            rx_hold <= rx_hold - 1;
        end else if (steady_flow) begin
            m_ready <= 1'b1;
        end else begin
            // short stalls often, long stalls rarely
            case ($urandom_range(0, 99)) inside
                [0:64]:  m_ready <= 1'b1;
                [65:97]: m_ready <= 1'b0;
                default: rx_hold <= $urandom_range(20, 80);
            endcase
        end
    end

    always @(posedge aclk) begin
        cls_pkg::out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (pending_vertices.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected vertex result %p", m_data);
            end else begin
                want = pending_vertices.pop_front();
                if (m_data.x_out !== want.x_out || m_data.y_out !== want.y_out ||
                    m_data.vertex_index !== want.vertex_index ||
                    m_data.final_of_contour !== want.final_of_contour) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"vertex mismatch: expected x=%0d y=%0d idx=%0d fin=%0b,",
                                  " got x=%0d y=%0d idx=%0d fin=%0b"},
                                 want.x_out, want.y_out, want.vertex_index,
                                 want.final_of_contour, m_data.x_out, m_data.y_out,
                                 m_data.vertex_index, m_data.final_of_contour);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Shared drivers
    // ------------------------------------------------------------------
    // Offer one vertex; returns at the falling edge after it was taken.
    task automatic send_vertex(input longint x, input longint y, input bit closing);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_data.x_in           = x[31:0];
        s_data.y_in           = y[31:0];
        s_data.closes_contour = closing;
        s_valid               = 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_vertex(s_data);
        items_sent++;
        @(negedge aclk);
    endtask

    // Sender pauses until every expected vertex is back and the block has settled.
    task automatic wait_drained();
        s_valid = 1'b0;
        while (pending_vertices.size() != 0) @(negedge aclk);
        repeat (SETTLE) @(negedge aclk);
    endtask

    task automatic apb_write(input int reg_index, input logic [31:0] value);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = 3'(reg_index * ADDR_STEP);
        pwdata  = value;
        @(negedge aclk);
        penable = 1'b1;
        @(posedge aclk);
        if (reg_index == cls_pkg::REG_TRAVEL_CAP) travel_limit = value[cls_pkg::MT_W-1:0];
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic apb_check_travel();
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = 3'(cls_pkg::REG_TRAVEL_CAP * ADDR_STEP);
        @(negedge aclk);
        penable = 1'b1;
        @(posedge aclk);
        if (prdata[cls_pkg::MT_W-1:0] !== travel_limit) begin
            mismatches++;
            if (mismatches <= 10)
                $display("travel cap readback: expected %0d, got %0d", travel_limit, prdata);
        end
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    task automatic set_travel(input logic [31:0] value);
        wait_drained();
        apb_write(cls_pkg::REG_TRAVEL_CAP, value);
        apb_check_travel();
    endtask

    function automatic longint pick_coord(input longint base);
        case ($urandom_range(0, 9))
            0:       pick_coord = longint'($signed($urandom()));
            1:       pick_coord = $urandom_range(0, 1) ? COORD_MAX : COORD_MIN;
            2:       pick_coord = base + $signed($urandom_range(0, 2000000)) - 1000000;
            default: pick_coord = base + $signed($urandom_range(0, 400)) - 200;
        endcase
        if (pick_coord > COORD_MAX) pick_coord = COORD_MAX;
        if (pick_coord < COORD_MIN) pick_coord = COORD_MIN;
    endfunction

    // A whole contour of random shape around a random center.
    task automatic send_contour(input int n_vertices);
        longint cx, cy;
        cx = $signed($urandom_range(0, 200000)) - 100000;
        cy = $signed($urandom_range(0, 200000)) - 100000;
        for (int k = 0; k < n_vertices; k++)
            send_vertex(pick_coord(cx), pick_coord(cy), k == n_vertices - 1);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // contours of one to three vertices come back untouched, vertex 0 last
    task automatic test_short_contours();
        set_travel(1000);
        send_vertex(COORD_MIN, COORD_MAX, 1'b1);
        send_vertex(5, -7, 1'b0);
        send_vertex(COORD_MAX, COORD_MIN, 1'b1);
        send_vertex(0, 0, 1'b0);
        send_vertex(-1, -1, 1'b0);
        send_vertex(123456, -654321, 1'b1);
    endtask

    // smallest contour that is smoothed, with moves inside and beyond the limit
    task automatic test_smoothing();
        set_travel(32'h7FFF_FFFF);             // largest cap, yet these moves still clamp
        send_vertex(COORD_MAX, COORD_MAX, 1'b0);
        send_vertex(COORD_MIN, COORD_MIN, 1'b0);
        send_vertex(COORD_MAX, COORD_MIN, 1'b0);
        send_vertex(COORD_MIN, COORD_MAX, 1'b1);
        set_travel(1);                         // almost every move is clamped
        send_vertex(0, 0, 1'b0);
        send_vertex(1000, 3, 1'b0);
        send_vertex(2000, -5, 1'b0);
        send_vertex(1000, 4000, 1'b0);
        send_vertex(-3, 7, 1'b1);
        set_travel(50);                        // a mix of clamped and free moves
        send_contour(6);
    endtask

    // zero travel passes vertices through; a write to the unused slot changes nothing
    task automatic test_zero_travel_and_unused_slot();
        set_travel(0);
        apb_write(1, 32'hFFFF_FFFF);
        send_contour(5);
        wait_drained();
        apb_write(1, 32'h0000_0000);
        apb_check_travel();
    endtask

    // receiver holds off long enough that the block has to stall its input
    task automatic test_backpressure();
        set_travel(300);
        hold_ask    = 600;
        steady_flow = 1'b1;
        send_contour(20);
        steady_flow = 1'b0;
        wait_drained();
    endtask

    // random contours over several travel settings
    task automatic test_random_contours();
        int stop_at;
        stop_at = items_sent + 100;
        while (items_sent < stop_at) begin
            case ($urandom_range(0, 4))
                0:       set_travel($urandom_range(1, 20));
                1:       set_travel($urandom_range(100, 100000));
                2:       set_travel($urandom() & 32'h7FFF_FFFF);
                3:       set_travel(0);
                default: set_travel($urandom_range(1000, 5000));
            endcase
            repeat ($urandom_range(1, 4))
                send_contour(($urandom_range(0, 5) == 0) ? $urandom_range(1, 3)
                                                         : $urandom_range(4, 14));
        end
        wait_drained();
    endtask

    initial begin
        aresetn         = 1'b0;
        s_valid         = 1'b0;
        s_data          = '0;
        m_ready         = 1'b0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        travel_limit    = '0;
        seen_in_contour = 0;
        mismatches      = 0;
        items_sent      = 0;
        results_seen    = 0;
        contours_sent   = 0;
        clamp_hits      = 0;
        cycles          = 0;
        rx_hold         = 0;
        hold_ask        = 0;
        steady_flow     = 1'b0;
        head0 = '{0, 0}; head1 = '{0, 0}; head2 = '{0, 0};
        trail_old = '{0, 0}; trail_new = '{0, 0};
        repeat (11) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        test_short_contours();
        test_smoothing();
        test_zero_travel_and_unused_slot();
        test_backpressure();
        test_random_contours();
        wait_drained();

        $display("covered %0d vertices in %0d contours, %0d results, %0d clamped moves",
                 items_sent, contours_sent, results_seen, clamp_hits);
        $display("short, clamped, saturating, zero-travel and stalled contours");
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
